// File: src/lgx_pkg.sv
// ----------------------------------------------------------------------------
// lgx_pkg
// Shared types, constants and the key table of the keystream descrambler.
// ----------------------------------------------------------------------------
package lgx_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OFFSET_W = 16;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned ADDR_W   = 2;

   localparam logic [WORD_W-1:0]   LCG_MUL       = 32'd214013;
   localparam logic [WORD_W-1:0]   LCG_INC       = 32'd2531011;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET  = 16'd3600;

   typedef enum logic [ADDR_W-1:0] {
      REG_SEED_BYTE    = 2'd0,
      REG_START_OFFSET = 2'd1,
      REG_FILE_LENGTH  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [WORD_W-1:0]   seed_next;
      logic [OFFSET_W-1:0] start_offset;
      logic [WORD_W-1:0]   file_length;
   } cfg_type;

   function automatic logic [BYTE_W-1:0] key_char(input logic [3:0] idx);
      logic [BYTE_W-1:0] c;
      case (idx)
         4'd0:    c = 8'h45;
         4'd1:    c = 8'h41;
         4'd2:    c = 8'h47;
         4'd3:    c = 8'h4C;
         4'd4:    c = 8'h53;
         4'd5:    c = 8'h5F;
         4'd6:    c = 8'h53;
         4'd7:    c = 8'h59;
         4'd8:    c = 8'h53;
         4'd9:    c = 8'h54;
         4'd10:   c = 8'h45;
         4'd11:   c = 8'h4D;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// File: src/lgx_csr.sv
// ----------------------------------------------------------------------------
// lgx_csr
// Configuration registers; the seed is held as the generator value that
// follows it, so a first byte can use it without a multiply.
// ----------------------------------------------------------------------------
module lgx_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [lgx_pkg::ADDR_W-1:0]    csr_addr,
   input  logic [lgx_pkg::WORD_W-1:0]    csr_wdata,
   output lgx_pkg::cfg_type              cfg
);

   logic [lgx_pkg::WORD_W-1:0]   seed_next_ff, seed_next_in;
   logic [lgx_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [lgx_pkg::WORD_W-1:0]   length_ff, length_in;
   logic [lgx_pkg::WORD_W-1:0]   seed_ext;

   assign seed_ext = {{(lgx_pkg::WORD_W-lgx_pkg::BYTE_W){csr_wdata[lgx_pkg::BYTE_W-1]}},
                      csr_wdata[lgx_pkg::BYTE_W-1:0]};

   always_comb begin
      seed_next_in = seed_next_ff;
      offset_in    = offset_ff;
      length_in    = length_ff;
      if (csr_we) begin
         case (lgx_pkg::reg_index_type'(csr_addr))
            lgx_pkg::REG_SEED_BYTE: begin
               seed_next_in = lgx_pkg::WORD_W'(seed_ext * lgx_pkg::LCG_MUL) + lgx_pkg::LCG_INC;
            end
            lgx_pkg::REG_START_OFFSET: begin
               offset_in = csr_wdata[lgx_pkg::OFFSET_W-1:0];
            end
            lgx_pkg::REG_FILE_LENGTH: begin
               length_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_next_ff <= lgx_pkg::LCG_INC;
         offset_ff    <= lgx_pkg::OFFSET_RESET;
         length_ff    <= '0;
      end else begin
         seed_next_ff <= seed_next_in;
         offset_ff    <= offset_in;
         length_ff    <= length_in;
      end
   end

   assign cfg.seed_next    = seed_next_ff;
   assign cfg.start_offset = offset_ff;
   assign cfg.file_length  = length_ff;

endmodule

// File: src/lgx_core.sv
// ----------------------------------------------------------------------------
// lgx_core
// Input register, region test, generator lookahead and key XOR, result
// register.
// ----------------------------------------------------------------------------
module lgx_core (
   input  logic                          clock,
   input  logic                          reset,
   input  lgx_pkg::cfg_type              cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lgx_pkg::BYTE_W-1:0]    req_data,
   input  logic                          req_first,
   input  logic                          req_last,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lgx_pkg::BYTE_W-1:0]    rsp_byte,
   output logic                          rsp_last,
   output logic                          rsp_short
);

   localparam int unsigned W  = lgx_pkg::WORD_W;
   localparam int unsigned M_W = 13;
   localparam logic [11:0] RECIP3 = 12'd2731;

   logic                   s1_valid_ff, s1_valid_in;
   logic [lgx_pkg::BYTE_W-1:0] s1_data_ff;
   logic                   s1_first_ff, s1_last_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [lgx_pkg::BYTE_W-1:0] out_byte_ff;
   logic                   out_last_ff, out_short_ff;
   logic [W-1:0]           gen_next_ff, gen_next_in;
   logic [W-1:0]           pos_ff, pos_in;

   logic                   s1_move, req_take;
   logic [W-1:0]           p, cur;
   logic                   short_file, in_region;
   logic [14:0]            r;
   logic [M_W-1:0]         m;
   logic [24:0]            prod;
   logic [11:0]            q;
   logic [M_W-1:0]         m_rem;
   logic [3:0]             idx;
   logic [lgx_pkg::BYTE_W-1:0] result;

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_take   = req_tvalid && req_tready;

   assign p   = s1_first_ff ? '0 : pos_ff;
   assign cur = s1_first_ff ? cfg.seed_next : gen_next_ff;

   assign short_file = {1'b0, cfg.file_length} <
                       (33'({cfg.start_offset}) + 33'd3);
   assign in_region  = !short_file
                       && (p >= W'(cfg.start_offset))
                       && ((p[0] ^ cfg.start_offset[0]) == 1'b0)
                       && (({1'b0, p} + 33'd2) < {1'b0, cfg.file_length});

   // key index: r mod 12 = 4 * ((r >> 2) mod 3) + r[1:0]
   assign r     = cur[30:16];
   assign m     = r[14:2];
   assign prod  = 25'(m) * 25'(RECIP3);
   assign q     = prod[24:13];
   assign m_rem = m - (M_W'(q) * 13'd3);
   assign idx   = {m_rem[1:0], r[1:0]};

   assign result = in_region ? (s1_data_ff ^ lgx_pkg::key_char(idx)) : s1_data_ff;

   assign gen_next_in = in_region ? (W'(cur * lgx_pkg::LCG_MUL) + lgx_pkg::LCG_INC) : cur;
   assign pos_in      = (p == '1) ? p : p + W'(1);

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         gen_next_ff  <= lgx_pkg::LCG_INC;
         pos_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_move) begin
            gen_next_ff <= gen_next_in;
            pos_ff      <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff  <= req_data;
         s1_first_ff <= req_first;
         s1_last_ff  <= req_last;
      end
      if (s1_move) begin
         out_byte_ff  <= result;
         out_last_ff  <= s1_last_ff;
         out_short_ff <= short_file;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_byte   = out_byte_ff;
   assign rsp_last   = out_last_ff;
   assign rsp_short  = out_short_ff;

endmodule

// File: src/lcg_keystream_xor_descrambler.sv
// ----------------------------------------------------------------------------
// lcg_keystream_xor_descrambler
// Byte stream descrambler: XORs bytes of the scrambled region with a key
// character chosen by a linear congruential generator.
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata=data_byte, tuser=first, tlast=last
//  rsp      out  rsp_tvalid/rsp_tready  tdata=out_byte, tuser=too_short, tlast=last_out
//  csr      in   csr_we                 csr_addr=index, csr_wdata=value
//
// One byte per cycle sustained while the receiver takes results; a result passes
// through the input register and then the result register before it can
// transfer out.
// The generator runs one step ahead in a register, so the key character
// comes from a register and one constant multiply sits on the update path.
// Reset clears both valid bits and the position and loads the generator with LCG_INC.
// A stalled result holds while the input register still takes one byte.
// ----------------------------------------------------------------------------
module lcg_keystream_xor_descrambler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] data_byte
   input  logic                          req_tuser,   // [0] first
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] out_byte
   output logic                          rsp_tuser,   // [0] too_short
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [lgx_pkg::ADDR_W-1:0]    csr_addr,
   input  logic [lgx_pkg::WORD_W-1:0]    csr_wdata
);

   lgx_pkg::cfg_type cfg;

   lgx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lgx_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_data   (req_tdata),
      .req_first  (req_tuser),
      .req_last   (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .rsp_short  (rsp_tuser)
   );

endmodule

// File: src/lgx_checker.sv
// ----------------------------------------------------------------------------
// lgx_checker
// Port-level checks of the descrambler: occupancy of its two registers and
// behaviour around reset and stalls.
// ----------------------------------------------------------------------------
module lgx_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   logic [1:0] pending_ff, pending_in;
   logic       in_xfer, out_xfer;

   assign in_xfer  = req_tvalid && req_tready;
   assign out_xfer = rsp_tvalid && rsp_tready;
   assign pending_in = pending_ff + 2'(in_xfer) - 2'(out_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != 2'd0))
      else $error("result shown with no byte in flight");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (pending_ff == 2'd2) && !rsp_tready |-> !req_tready)
      else $error("byte taken with both registers full");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind lcg_keystream_xor_descrambler lgx_checker u_lgx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: tb/descrambler_monitor.sv
// ----------------------------------------------------------------------------
// descrambler_monitor
// Watches the request, result and register ports of the keystream
// descrambler. Keeps its own copy of the registers, the position counter and
// the generator, works out the plaintext byte for every request transfer and
// compares each result transfer with the oldest one still waiting.
// ----------------------------------------------------------------------------
module descrambler_monitor (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [7:0]                 req_tdata,
   input  logic                       req_tuser,
   input  logic                       req_tlast,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [7:0]                 rsp_tdata,
   input  logic                       rsp_tuser,
   input  logic                       rsp_tlast,
   input  logic                       csr_we,
   input  logic [lgx_pkg::ADDR_W-1:0] csr_addr,
   input  logic [lgx_pkg::WORD_W-1:0] csr_wdata,
   output int                         mismatches,
   output int                         outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_out;
      logic       too_short;
   } plain_result_type;

   localparam logic [7:0] KEY_BYTES [0:11] = '{
      8'h45, 8'h41, 8'h47, 8'h4C, 8'h53, 8'h5F,
      8'h53, 8'h59, 8'h53, 8'h54, 8'h45, 8'h4D
   };

   logic [7:0]       seed_reg   = '0;
   logic [15:0]      offset_reg = 16'd3600;
   logic [31:0]      length_reg = '0;
   logic [31:0]      lcg        = '0;
   logic [31:0]      pos        = '0;
   plain_result_type plain_q [$];
   int               fail_count = 0;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic report(input string what);
      $display("ERROR %0t ns: %s", $time, what);
      fail_count++;
   endtask

   function automatic plain_result_type descramble_byte(input logic [7:0] din,
                                                        input logic first_mark,
                                                        input logic last_mark);
      plain_result_type r;
      logic             short_file;
      logic [31:0]      delta;
      short_file = {1'b0, length_reg} < ({17'b0, offset_reg} + 33'd3);
      if (first_mark) begin
         pos = '0;
         lcg = {{24{seed_reg[7]}}, seed_reg};
      end
      delta = pos - {16'b0, offset_reg};
      r.out_byte = din;
      if (!short_file && pos >= {16'b0, offset_reg} && !delta[0] &&
          ({1'b0, pos} + 33'd2 < {1'b0, length_reg})) begin
         lcg = lcg * 32'd214013 + 32'd2531011;
         r.out_byte = din ^ KEY_BYTES[int'(lcg[30:16]) % 12];
      end
      if (pos != 32'hFFFF_FFFF)
         pos = pos + 32'd1;
      r.last_out  = last_mark;
      r.too_short = short_file;
      return r;
   endfunction

   always @(posedge clock) begin
      plain_result_type want;
      if (reset) begin
         seed_reg   = '0;
         offset_reg = 16'd3600;
         length_reg = '0;
         lcg        = '0;
         pos        = '0;
         plain_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (plain_q.size() == 0) begin
               report($sformatf("result transfer with nothing expected: byte %02h",
                                rsp_tdata));
            end else begin
               want = plain_q.pop_front();
               if (rsp_tdata !== want.out_byte)
                  report($sformatf("out_byte %02h, expected %02h", rsp_tdata, want.out_byte));
               if (rsp_tlast !== want.last_out)
                  report($sformatf("last_out %b, expected %b", rsp_tlast, want.last_out));
               if (rsp_tuser !== want.too_short)
                  report($sformatf("too_short %b, expected %b", rsp_tuser, want.too_short));
            end
         end
         if (csr_we) begin
            case (csr_addr)
               lgx_pkg::REG_SEED_BYTE:    seed_reg   = csr_wdata[7:0];
               lgx_pkg::REG_START_OFFSET: offset_reg = csr_wdata[15:0];
               lgx_pkg::REG_FILE_LENGTH:  length_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            plain_q.push_back(descramble_byte(req_tdata, req_tuser, req_tlast));
      end
      outstanding <= plain_q.size();
      mismatches  <= fail_count;
   end

endmodule

// File: tb/tb_lcg_keystream_xor_descrambler.sv
// ----------------------------------------------------------------------------
// tb_lcg_keystream_xor_descrambler
// Drives byte files into the keystream descrambler under bursty input and a
// stalling receiver, across many register settings: a directed opening on
// the region edges, then random files. Checking is done by
// descrambler_monitor.
// ----------------------------------------------------------------------------
module tb_lcg_keystream_xor_descrambler;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {FILE_NORMAL, FILE_NO_FIRST, FILE_NO_LAST, FILE_EXTRA_FIRST}
      file_style_type;
   typedef enum int {CFG_SPAN, CFG_SHORT, CFG_WIDE, CFG_ENDLESS, CFG_EDGE} cfg_style_type;
   typedef enum int {RX_FREE, RX_COIN, RX_PATTERN, RX_SLOW} rx_mode_type;

   localparam logic [lgx_pkg::ADDR_W-1:0] REG_SPARE = 2'd3;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata  = '0;
   logic                       req_tuser  = 1'b0;
   logic                       req_tlast  = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [7:0]                 rsp_tdata;
   logic                       rsp_tuser;
   logic                       rsp_tlast;
   logic                       csr_we     = 1'b0;
   logic [lgx_pkg::ADDR_W-1:0] csr_addr   = '0;
   logic [lgx_pkg::WORD_W-1:0] csr_wdata  = '0;
   int                         mismatches;
   int                         outstanding;

   int          sent_count = 0;
   int          burst_left = 0;
   rx_mode_type rx_mode    = RX_FREE;
   int          rx_left    = 0;
   logic [15:0] rx_pattern = '1;

   logic [15:0]   cur_offset;
   logic [31:0]   cur_length;
   cfg_style_type cfg_style;
   int            pick;
   int            n_files;
   int            n;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   lcg_keystream_xor_descrambler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   descrambler_monitor u_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode    = rx_mode_type'($urandom_range(0, 3));
         rx_pattern = 16'($urandom());
         rx_left    = $urandom_range(16, 200);
      end
      rx_left--;
      case (rx_mode)
         RX_FREE:    rsp_tready <= 1'b1;
         RX_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
         RX_PATTERN: begin
            rsp_tready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
         end
         default:    rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic send_byte(input logic [7:0] value, input logic first_mark,
                            input logic last_mark);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= first_mark;
      req_tlast  <= last_mark;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic send_file(input int len, input file_style_type style);
      int extra_at;
      extra_at = (style == FILE_EXTRA_FIRST && len > 2) ? $urandom_range(1, len - 1) : -1;
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom_range(0, 255)),
                   (i == 0 && style != FILE_NO_FIRST) || i == extra_at,
                   i == len - 1 && style != FILE_NO_LAST);
   endtask

   task automatic write_reg(input logic [lgx_pkg::ADDR_W-1:0] idx,
                            input logic [lgx_pkg::WORD_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: too short, no first mark yet
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h80, 1'b0, 1'b1);
      settle();

      // carry on from reset position and generator without a first mark
      write_reg(lgx_pkg::REG_START_OFFSET, 32'd3);
      write_reg(lgx_pkg::REG_FILE_LENGTH, 32'd12);
      send_byte(8'h55, 1'b0, 1'b0);
      send_byte(8'hAA, 1'b0, 1'b0);
      send_byte(8'h0F, 1'b0, 1'b0);
      send_byte(8'hF0, 1'b0, 1'b0);
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'hFE, 1'b0, 1'b1);
      settle();

      // most negative seed, smallest length that is not short, bytes past the end
      write_reg(lgx_pkg::REG_SEED_BYTE, 32'h80);
      write_reg(lgx_pkg::REG_START_OFFSET, 32'd0);
      write_reg(lgx_pkg::REG_FILE_LENGTH, 32'd3);
      send_byte(8'hFF, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h7F, 1'b0, 1'b0);
      send_byte(8'h80, 1'b0, 1'b0);
      send_byte(8'h45, 1'b0, 1'b1);
      settle();

      // largest offset, length one short of the limit
      write_reg(lgx_pkg::REG_SEED_BYTE, 32'h7F);
      write_reg(lgx_pkg::REG_START_OFFSET, 32'hFFFF);
      write_reg(lgx_pkg::REG_FILE_LENGTH, 32'd65537);
      send_byte(8'h12, 1'b1, 1'b0);
      send_byte(8'h34, 1'b0, 1'b0);
      send_byte(8'h56, 1'b0, 1'b1);
      settle();

      // single-byte file, then a restart in the middle of a file
      write_reg(lgx_pkg::REG_SEED_BYTE, 32'hFF);
      write_reg(lgx_pkg::REG_START_OFFSET, 32'd1);
      write_reg(lgx_pkg::REG_FILE_LENGTH, 32'd8);
      write_reg(REG_SPARE, 32'hFFFF_FFFF);
      send_byte(8'h41, 1'b1, 1'b1);
      for (int i = 0; i < 8; i++)
         send_byte(8'($urandom_range(0, 255)), i == 0 || i == 3, i == 7);
      settle();

      while (sent_count < 1750) begin
         pick      = $urandom_range(0, 9);
         cfg_style = (pick < 6) ? CFG_SPAN : cfg_style_type'(pick - 5);
         case (cfg_style)
            CFG_SPAN: begin
               cur_offset = 16'($urandom_range(0, 6));
               cur_length = 32'(cur_offset) + 32'd3 + $urandom_range(0, 30);
            end
            CFG_SHORT: begin
               cur_offset = 16'($urandom_range(0, 20));
               cur_length = $urandom_range(0, 32'(cur_offset) + 32'd2);
            end
            CFG_WIDE: begin
               cur_offset = 16'($urandom_range(0, 65535));
               cur_length = $urandom();
            end
            CFG_ENDLESS: begin
               cur_offset = 16'($urandom_range(0, 6));
               cur_length = 32'hFFFF_FFFF;
            end
            default: begin
               cur_offset = 16'($urandom_range(0, 65535));
               cur_length = 32'(cur_offset) + $urandom_range(2, 3);
            end
         endcase
         if ($urandom_range(0, 3) != 0)
            write_reg(lgx_pkg::REG_SEED_BYTE, $urandom_range(0, 255));
         write_reg(lgx_pkg::REG_START_OFFSET, 32'(cur_offset));
         write_reg(lgx_pkg::REG_FILE_LENGTH, cur_length);
         n_files = $urandom_range(1, 4);
         repeat (n_files) begin
            n = (cur_length <= 64) ? int'(cur_length) : $urandom_range(1, 48);
            if ($urandom_range(0, 4) == 0)
               n = n + $urandom_range(0, 4) - 2;
            if (n < 1)
               n = 1;
            pick = $urandom_range(0, 9);
            send_file(n, (pick < 3) ? file_style_type'(pick + 1) : FILE_NORMAL);
         end
         settle();
      end

      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
